@@ hw/rtl/esnp_pkg.sv @@
// ----------------------------------------------------------------------------
// esnp_pkg
// Shared constants and types for the EDID size and name parser.
// ----------------------------------------------------------------------------
package esnp_pkg;

  localparam int NAME_MAX_DEF = 13;
  localparam int CNT_W        = 4;

  localparam logic [7:0] OFS_HSIZE_CM = 8'd21;
  localparam logic [7:0] OFS_VSIZE_CM = 8'd22;
  localparam logic [7:0] OFS_DTD_HMM  = 8'd66;
  localparam logic [7:0] OFS_DTD_VMM  = 8'd67;
  localparam logic [7:0] OFS_DTD_HI   = 8'd68;
  localparam logic [7:0] DESC_FIRST   = 8'd54;
  localparam logic [7:0] DESC_END     = 8'd126;
  localparam logic [4:0] DESC_LAST    = 5'd17;
  localparam logic [4:0] DESC_TXT0    = 5'd5;
  localparam logic [4:0] DESC_TAG_IX  = 5'd3;
  localparam logic [7:0] NAME_TAG     = 8'hFC;
  localparam logic [7:0] NAME_END     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef struct packed {
    logic             vld;
    logic [11:0]      width_mm;
    logic [11:0]      height_mm;
    logic [CNT_W-1:0] nchars;
  } esnp_sum_t;

endpackage

@@ hw/rtl/esnp_if.sv @@
// ----------------------------------------------------------------------------
// esnp_if
// Valid/ready channels for EDID input bytes and parser result words.
// ----------------------------------------------------------------------------
interface esnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] edid_byte;
  logic       end_of_block;

  modport source (output valid, output edid_byte, output end_of_block, input ready);
  modport sink   (input valid, input edid_byte, input end_of_block, output ready);
endinterface

interface esnp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] width_mm;
  logic [11:0] height_mm;
  logic        name_present;
  logic [7:0]  name_char;
  logic        last_result;

  modport source (output valid, output width_mm, output height_mm, output name_present,
                  output name_char, output last_result, input ready);
  modport sink   (input valid, input width_mm, input height_mm, input name_present,
                  input name_char, input last_result, output ready);
endinterface

@@ hw/rtl/esnp_name_ram.sv @@
// ----------------------------------------------------------------------------
// esnp_name_ram
// Name character store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module esnp_name_ram #(
  parameter int DEPTH = 13,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/esnp_scan.sv @@
// ----------------------------------------------------------------------------
// esnp_scan
// Byte intake: position count, size bytes, descriptor header check and
// name capture into the name store; builds the block summary.
// ----------------------------------------------------------------------------
module esnp_scan import esnp_pkg::*; #(
  parameter int NAME_MAX = NAME_MAX_DEF,
  parameter int AW       = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    edid_byte,
  input  logic          end_of_block,
  output logic          busy,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output esnp_sum_t     sum
);

  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(NAME_MAX);

  logic [7:0]       pos_r, pos_nxt;
  logic [4:0]       di_r, di_nxt;
  logic [7:0]       s0_r, s1_r, s2_r, s3_r, s4_r;
  logic [7:0]       s0_nxt, s1_nxt, s2_nxt, s3_nxt, s4_nxt;
  logic             hok_r, hok_nxt;
  logic             found_r, found_nxt;
  logic             stop_r, stop_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] trim_r, trim_nxt;
  logic             fin_r, fin_nxt;
  logic             in_desc;
  logic [11:0]      dtd_w, dtd_h, cm_w, cm_h;

  assign in_desc = (pos_r >= DESC_FIRST) && (pos_r < DESC_END);
  assign waddr   = len_r[AW-1:0];
  assign wdata   = edid_byte;
  assign busy    = fin_r;

  always_comb begin
    pos_nxt   = pos_r;
    di_nxt    = di_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    s3_nxt    = s3_r;
    s4_nxt    = s4_r;
    hok_nxt   = hok_r;
    found_nxt = found_r;
    stop_nxt  = stop_r;
    len_nxt   = len_r;
    trim_nxt  = trim_r;
    fin_nxt   = 1'b0;
    we        = 1'b0;
    if (fin_r) begin
      pos_nxt   = '0;
      di_nxt    = '0;
      s0_nxt    = '0;
      s1_nxt    = '0;
      s2_nxt    = '0;
      s3_nxt    = '0;
      s4_nxt    = '0;
      hok_nxt   = 1'b0;
      found_nxt = 1'b0;
      stop_nxt  = 1'b0;
      len_nxt   = '0;
      trim_nxt  = '0;
    end else if (take) begin
      fin_nxt = end_of_block;
      if (!pos_r[7]) begin
        pos_nxt = pos_r + 8'd1;
        case (pos_r)
          OFS_HSIZE_CM: s0_nxt = edid_byte;
          OFS_VSIZE_CM: s1_nxt = edid_byte;
          OFS_DTD_HMM:  s2_nxt = edid_byte;
          OFS_DTD_VMM:  s3_nxt = edid_byte;
          OFS_DTD_HI:   s4_nxt = edid_byte;
          default: ;
        endcase
        if (in_desc) begin
          di_nxt = (di_r == DESC_LAST) ? 5'd0 : di_r + 5'd1;
          if (!found_r) begin
            if (di_r == 5'd0) begin
              hok_nxt = (edid_byte == 8'd0);
            end else if (di_r == 5'd1) begin
              hok_nxt = hok_r && (edid_byte == 8'd0);
            end else if (di_r == DESC_TAG_IX && hok_r && edid_byte == NAME_TAG) begin
              found_nxt = 1'b1;
              stop_nxt  = 1'b0;
              len_nxt   = '0;
              trim_nxt  = '0;
            end
          end else if (!stop_r && di_r >= DESC_TXT0) begin
            if (edid_byte == NAME_END) begin
              stop_nxt = 1'b1;
            end else if (len_r < LEN_MAX) begin
              we      = 1'b1;
              len_nxt = len_r + 1'b1;
              if (edid_byte != CHAR_SPACE) begin
                trim_nxt = len_r + 1'b1;
              end
            end
            if (di_r == DESC_LAST) begin
              stop_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  assign dtd_w = {s4_r[7:4], s2_r};
  assign dtd_h = {s4_r[3:0], s3_r};
  assign cm_w  = ({4'd0, s0_r} << 3) + ({4'd0, s0_r} << 1);
  assign cm_h  = ({4'd0, s1_r} << 3) + ({4'd0, s1_r} << 1);

  always_comb begin
    sum.vld       = fin_r;
    sum.width_mm  = '0;
    sum.height_mm = '0;
    sum.nchars    = '0;
    if (pos_r[7]) begin
      if (dtd_w != 12'd0 && dtd_h != 12'd0) begin
        sum.width_mm  = dtd_w;
        sum.height_mm = dtd_h;
      end else if (s0_r != 8'd0 && s1_r != 8'd0) begin
        sum.width_mm  = cm_w;
        sum.height_mm = cm_h;
      end
      if (found_r) begin
        sum.nchars = trim_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      di_r    <= '0;
      s0_r    <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
      s3_r    <= '0;
      s4_r    <= '0;
      hok_r   <= 1'b0;
      found_r <= 1'b0;
      stop_r  <= 1'b0;
      len_r   <= '0;
      trim_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      di_r    <= di_nxt;
      s0_r    <= s0_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      s3_r    <= s3_nxt;
      s4_r    <= s4_nxt;
      hok_r   <= hok_nxt;
      found_r <= found_nxt;
      stop_r  <= stop_nxt;
      len_r   <= len_nxt;
      trim_r  <= trim_nxt;
      fin_r   <= fin_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r <= LEN_MAX) && (trim_r <= len_r))
    else $error("name length out of range");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 8'd128)
    else $error("byte position past saturation");

  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> (pos_r == 8'd0) && !found_r && (len_r == '0))
    else $error("block state not cleared after summary");

endmodule

@@ hw/rtl/esnp_emit.sv @@
// ----------------------------------------------------------------------------
// esnp_emit
// Result sequencer: reads name characters from the name store one by one
// and drives the result word register.
// ----------------------------------------------------------------------------
module esnp_emit import esnp_pkg::*; #(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  esnp_sum_t     sum,
  output logic          idle,
  output logic [AW-1:0] raddr,
  input  logic [7:0]    rdata,
  esnp_out_if.source    out_ch
);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t           state_r;
  logic [11:0]      w_r, h_r;
  logic [CNT_W-1:0] n_r, k_r;
  logic             primed_r;
  logic             out_vld_r;
  logic [11:0]      out_w_r, out_h_r;
  logic             out_np_r, out_last_r;
  logic [7:0]       out_c_r;
  logic             slot_free;
  logic             at_last;
  logic             load;

  assign slot_free = !out_vld_r || out_ch.ready;
  assign at_last   = (k_r + 1'b1) == n_r;
  assign raddr     = k_r[AW-1:0];
  assign idle      = (state_r == S_IDLE);
  assign load      = (state_r == S_EMIT) && slot_free && ((n_r == '0) || primed_r);

  assign out_ch.valid        = out_vld_r;
  assign out_ch.width_mm     = out_w_r;
  assign out_ch.height_mm    = out_h_r;
  assign out_ch.name_present = out_np_r;
  assign out_ch.name_char    = out_c_r;
  assign out_ch.last_result  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      primed_r  <= 1'b0;
      k_r       <= '0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (sum.vld) begin
            w_r      <= sum.width_mm;
            h_r      <= sum.height_mm;
            n_r      <= sum.nchars;
            k_r      <= '0;
            primed_r <= 1'b0;
            state_r  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (n_r == '0) begin
            if (slot_free) begin
              out_w_r    <= w_r;
              out_h_r    <= h_r;
              out_np_r   <= 1'b0;
              out_c_r    <= 8'd0;
              out_last_r <= 1'b1;
              state_r    <= S_IDLE;
            end
          end else if (!primed_r) begin
            primed_r <= 1'b1;
          end else if (slot_free) begin
            out_w_r    <= w_r;
            out_h_r    <= h_r;
            out_np_r   <= 1'b1;
            out_c_r    <= rdata;
            out_last_r <= at_last;
            primed_r   <= 1'b0;
            if (at_last) begin
              state_r <= S_IDLE;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && n_r != '0) |-> (k_r < n_r))
    else $error("name index past name length");

  a_noname_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_np_r) |-> (out_last_r && out_c_r == 8'd0))
    else $error("nameless result must be single and blank");

  a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sum.vld |-> (state_r == S_IDLE))
    else $error("summary arrived while emitting");

endmodule

@@ hw/rtl/edid_size_and_name_parser.sv @@
// ----------------------------------------------------------------------------
// edid_size_and_name_parser
// Extracts the physical image size and the monitor name from an EDID base
// block delivered one byte per word.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle while a block streams in.
// After the flagged byte the input stalls until the final result word is
// loaded. With no name a single result word follows the registered summary;
// each name character waits for the name store's registered read.
// Reset: synchronous, active low; clears all control state. The name store
// is not cleared; only entries written for the current block are read.
module edid_size_and_name_parser import esnp_pkg::*; #(
  parameter int NAME_MAX = NAME_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  esnp_in_if.sink    in_ch,
  esnp_out_if.source out_ch
);

  localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  logic          take;
  logic          scan_busy;
  logic          emit_idle;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  esnp_sum_t     sum;

  assign in_ch.ready = !scan_busy && emit_idle;
  assign take        = in_ch.valid && in_ch.ready;

  esnp_scan #(.NAME_MAX(NAME_MAX), .AW(AW)) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .edid_byte    (in_ch.edid_byte),
    .end_of_block (in_ch.end_of_block),
    .busy         (scan_busy),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .sum          (sum)
  );

  esnp_name_ram #(.DEPTH(NAME_MAX), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  esnp_emit #(.AW(AW)) u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .sum    (sum),
    .idle   (emit_idle),
    .raddr  (raddr),
    .rdata  (rdata),
    .out_ch (out_ch)
  );

endmodule
